>>> sv/fnms_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and byte helpers of the fuzzy name match scorer
package fnms_pkg;

	localparam int PATTERN_MAX_DEF = 32;
	localparam int PAT_BYTES       = 32;
	localparam int SCORE_W         = 27;
	localparam int CFG_IDX_W       = 3;

	typedef logic signed [SCORE_W-1:0] score_t;
	typedef logic signed [SCORE_W:0]   score_wide_t;

	localparam score_t SC_NONE   = -27'sd1;
	localparam score_t SC_ZERO   = 27'sd0;
	localparam score_t SC_PROPER = 27'sh0100000;
	localparam score_t SC_WILD   = 27'sh0000201;
	localparam score_t SC_ADJ    = 27'sh0000400;
	localparam score_t SC_SAT    = 27'sh3FFFFFF;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DASH       = 8'h2D;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PLEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_UTF8 = 3'd5;

	// values broadcast to every cell for one byte
	typedef struct packed {
		logic [7:0] ch;
		logic       at_ws;
		logic       utf8;
		logic       clear;
	} bcast_t;

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic [7:0] norm_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (is_upper(c)) begin
			r = c + 8'd32;
		end else if (c == CH_DASH) begin
			r = CH_UNDERSCORE;
		end
		return r;
	endfunction

	function automatic logic is_delim(input logic [7:0] c);
		return (c == 8'h2E) || (c == CH_UNDERSCORE) || (c == 8'h2F) || (c == 8'h2A) ||
			(c == 8'h20) || (c == 8'h27) || (c == 8'h22);
	endfunction

	function automatic score_t sat_add(input score_t a, input score_t b);
		score_wide_t s;
		s = score_wide_t'(a) + score_wide_t'(b);
		if (s > score_wide_t'(SC_SAT)) begin
			s = score_wide_t'(SC_SAT);
		end
		return s[SCORE_W-1:0];
	endfunction

endpackage

>>> sv/fnms_cell.sv
`timescale 1ns / 1ps
// one pattern position of the scoring column
module fnms_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head,
	input  logic            en,
	input  fnms_pkg::bcast_t bc,
	input  logic [7:0]      pat_raw,
	input  logic [7:0]      prev_pat_raw,
	input  fnms_pkg::score_t prev_best,
	input  fnms_pkg::score_t prev_here,
	output fnms_pkg::score_t best_q,
	output fnms_pkg::score_t here_q,
	output fnms_pkg::score_t best_nx
);

	logic [7:0]       pc;
	logic [7:0]       prevc;
	logic             sow;
	logic             fail;
	fnms_pkg::score_t amount;
	fnms_pkg::score_t here;
	fnms_pkg::score_t cand;
	fnms_pkg::score_t best_n;
	fnms_pkg::score_t here_n;

	always_comb begin
		pc     = fnms_pkg::norm_byte(pat_raw);
		prevc  = fnms_pkg::norm_byte(prev_pat_raw);
		sow    = fnms_pkg::is_delim(prevc) || fnms_pkg::is_upper(pat_raw);
		amount = fnms_pkg::SC_ZERO;
		fail   = 1'b0;
		here   = fnms_pkg::SC_NONE;
		cand   = fnms_pkg::SC_NONE;
		best_n = best_q;
		here_n = here_q;
		if (en) begin
			if (head) begin
				// first position: no predecessor
				if (bc.ch == pc) begin
					amount = bc.at_ws ? fnms_pkg::SC_PROPER : fnms_pkg::SC_ZERO;
					if (!(best_q > amount)) begin
						best_n = amount;
					end
					here_n = amount;
				end else begin
					here_n = fnms_pkg::SC_NONE;
				end
			end else if (pc == fnms_pkg::CH_UNDERSCORE) begin
				// wildcard delimiter passes the previous best through
				best_n = prev_best;
				here_n = prev_best;
			end else begin
				fail = (bc.ch != pc) || (prev_best < 0);
				if (bc.at_ws) begin
					amount = sow ? fnms_pkg::SC_PROPER : fnms_pkg::SC_WILD;
				end
				if (!fail && (prevc == fnms_pkg::CH_UNDERSCORE) &&
					(amount != fnms_pkg::SC_PROPER)) begin
					fail = 1'b1;
				end
				here = fnms_pkg::sat_add(prev_best, amount);
				// utf8 continuation byte only extends an adjacent match
				if (bc.utf8 && (pc[7:6] == 2'b10)) begin
					if (prev_here < 0) begin
						fail = 1'b1;
					end
					here = fnms_pkg::SC_ZERO;
				end
				if (fail) begin
					here_n = fnms_pkg::SC_NONE;
				end else begin
					if ((prev_here >= 0) && !fnms_pkg::is_delim(pc)) begin
						cand = fnms_pkg::sat_add(prev_here, fnms_pkg::SC_ADJ);
						if (cand > here) begin
							here = cand;
						end
					end
					here_n = here;
					if (here > best_q) begin
						best_n = here;
					end
				end
			end
		end
		best_nx = best_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= fnms_pkg::SC_NONE;
			here_q <= fnms_pkg::SC_NONE;
		end else if (bc.clear) begin
			best_q <= fnms_pkg::SC_NONE;
			here_q <= fnms_pkg::SC_NONE;
		end else begin
			best_q <= best_n;
			here_q <= here_n;
		end
	end

endmodule

>>> sv/fnms_out_skid.sv
`timescale 1ns / 1ps
// two-entry output register with skid slot for the score stream
module fnms_out_skid (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  fnms_pkg::score_t             push_score,
	output logic                         space,
	output logic                         out_valid,
	input  logic                         out_ready,
	output fnms_pkg::score_t             out_score
);

	logic             main_valid_q;
	logic             skid_valid_q;
	fnms_pkg::score_t main_q;
	fnms_pkg::score_t skid_q;
	logic             pop;

	assign space     = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_score = main_q;
	assign pop       = main_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				main_valid_q <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
			if (push && space) begin
				if (!main_valid_q || pop) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
		if (push && space) begin
			if (!main_valid_q || pop) begin
				main_q <= push_score;
			end else begin
				skid_q <= push_score;
			end
		end
	end

endmodule

>>> sv/fuzzy_name_match_scorer.sv
`timescale 1ns / 1ps
// top level of the fuzzy name match scorer: config registers, cell row, output stage
//
// scores a candidate name, streamed one byte per item, against a pattern of up to
// PATTERN_MAX bytes held in config registers 0..3 (raw bytes, byte 0 lowest), with
// pattern_length at index 4 and utf8_mode at index 5. a row of PATTERN_MAX cells
// holds the dynamic-programming column: each cell keeps a best and a match-here
// score and reads its left neighbor's registered values, so one byte is absorbed
// per clock cycle and s_axis accepts one item every cycle while the output stage
// has room. on the item marked tlast the score of cell pattern_length-1 (or 0 for
// an empty pattern, -1 for no match) is latched into the output stage and shows on
// m_axis from its main register; the column is cleared at the edge that accepts the item, so
// the next string may start in the following cycle. the output stage holds two
// scores; s_axis tready drops only when both are waiting. config writes are always
// ready and are meant to be issued while no string is in flight.
module fuzzy_name_match_scorer #(
	parameter int PATTERN_MAX = fnms_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// stream in
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] name_byte
	input  logic                           s_axis_tlast,  // last_byte
	// stream out
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata,  // [26:0] match_score, rest zero
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fnms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	// config registers
	logic [7:0] pat_raw_q [fnms_pkg::PAT_BYTES];
	logic [5:0] pat_len_q;
	logic       utf8_q;

	// string state
	logic             after_delim_q;
	logic [LEN_W-1:0] bytes_seen_q;

	logic             in_fire;
	logic             cfg_fire;
	logic             out_space;
	logic [LEN_W-1:0] plen;
	logic [IDX_W-1:0] sel;
	logic [7:0]       ch_raw;
	fnms_pkg::bcast_t bc;
	fnms_pkg::score_t final_score;
	fnms_pkg::score_t out_score;

	logic [PATTERN_MAX-1:0] cell_en;
	fnms_pkg::score_t       best_q  [PATTERN_MAX];
	fnms_pkg::score_t       here_q  [PATTERN_MAX];
	fnms_pkg::score_t       best_nx [PATTERN_MAX];

	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign s_axis_tready = out_space;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign ch_raw        = s_axis_tdata;

	// config register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < fnms_pkg::PAT_BYTES; p++) begin
				pat_raw_q[p] <= 8'h00;
			end
			pat_len_q <= 6'd0;
			utf8_q    <= 1'b1;
		end else if (cfg_fire) begin
			unique case (cfg_index) inside
				fnms_pkg::CFG_PAT0, fnms_pkg::CFG_PAT1,
				fnms_pkg::CFG_PAT2, fnms_pkg::CFG_PAT3: begin
					for (int p = 0; p < fnms_pkg::PAT_BYTES; p++) begin
						if (cfg_index == fnms_pkg::CFG_PAT0 + 3'(p / 8)) begin
							pat_raw_q[p] <= cfg_data[8*(p%8) +: 8];
						end
					end
				end
				fnms_pkg::CFG_PLEN: pat_len_q <= cfg_data[5:0];
				fnms_pkg::CFG_UTF8: utf8_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pattern length clamped to the cell count
	always_comb begin
		if (32'(pat_len_q) > PATTERN_MAX) begin
			plen = LEN_W'(PATTERN_MAX);
		end else begin
			plen = LEN_W'(pat_len_q);
		end
		sel = IDX_W'(plen - LEN_W'(1));
	end

	// byte broadcast: normalized byte, word-start flag, mode, end of string
	always_comb begin
		bc.ch    = fnms_pkg::norm_byte(ch_raw);
		bc.at_ws = after_delim_q || fnms_pkg::is_upper(ch_raw);
		bc.utf8  = utf8_q;
		bc.clear = in_fire && s_axis_tlast;
	end

	// a cell steps only once the string is long enough to reach it and it lies within the pattern length
	always_comb begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			cell_en[k] = in_fire && (LEN_W'(k) <= bytes_seen_q) && (LEN_W'(k) < plen);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_delim_q <= 1'b1;
			bytes_seen_q  <= '0;
		end else if (in_fire) begin
			if (s_axis_tlast) begin
				after_delim_q <= 1'b1;
				bytes_seen_q  <= '0;
			end else begin
				after_delim_q <= fnms_pkg::is_delim(bc.ch);
				if (bytes_seen_q != LEN_W'(PATTERN_MAX)) begin
					bytes_seen_q <= bytes_seen_q + LEN_W'(1);
				end
			end
		end
	end

	// the cell row
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [7:0]       raw_k;
		logic [7:0]       raw_prev;
		fnms_pkg::score_t nb_best;
		fnms_pkg::score_t nb_here;

		// positions past the register file read as zero bytes
		if (k < fnms_pkg::PAT_BYTES) begin : g_raw
			assign raw_k = pat_raw_q[k];
		end else begin : g_raw_zero
			assign raw_k = 8'h00;
		end

		if (k == 0) begin : g_head
			assign raw_prev = 8'h00;
			assign nb_best  = fnms_pkg::SC_NONE;
			assign nb_here  = fnms_pkg::SC_NONE;
		end else begin : g_link
			if (k - 1 < fnms_pkg::PAT_BYTES) begin : g_prev
				assign raw_prev = pat_raw_q[k-1];
			end else begin : g_prev_zero
				assign raw_prev = 8'h00;
			end
			assign nb_best = best_q[k-1];
			assign nb_here = here_q[k-1];
		end

		fnms_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.head        (k == 0),
			.en          (cell_en[k]),
			.bc          (bc),
			.pat_raw     (raw_k),
			.prev_pat_raw(raw_prev),
			.prev_best   (nb_best),
			.prev_here   (nb_here),
			.best_q      (best_q[k]),
			.here_q      (here_q[k]),
			.best_nx     (best_nx[k])
		);
	end

	// final score taken from the updated column before it clears
	assign final_score = (plen == '0) ? fnms_pkg::SC_ZERO : best_nx[sel];

	fnms_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (bc.clear),
		.push_score(final_score),
		.space     (out_space),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_score (out_score)
	);

	assign m_axis_tdata = {5'b00000, out_score};

endmodule

>>> sv/fnms_checker.sv
`timescale 1ns / 1ps
// port-level checks of the fuzzy name match scorer, bound to the top level
module fnms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a waiting score stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("score dropped while stalled");

	// a waiting score keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("score changed while stalled");

	// a score appears only after an item that ends a string
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
		else $error("score without end of string");

	// a score is no match or a saturated non-negative value, padding zero
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:27] == 5'b00000) &&
			(!m_axis_tdata[26] || (m_axis_tdata[26:0] == 27'h7FFFFFF)))
		else $error("score out of range");

endmodule

bind fuzzy_name_match_scorer fnms_checker u_fnms_checker (.*);
